// ===== design/assert_macros.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, sampled on the rising clock, off during reset.
`define CHB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition that must never be true at a clock edge.
`define CHB_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== design/chb_pkg.sv =====
// Shared types and constants for the chunked body decoder.
package chb_pkg;

  localparam int SIZE_BITS_DEFAULT   = 24;
  localparam int LENGTH_BITS_DEFAULT = 24;
  localparam int CFG_BITS            = 24;
  localparam int LEN_OUT_BITS        = 24;
  localparam int QUEUE_DEPTH         = 4;
  localparam logic [CFG_BITS-1:0] MAX_CHUNK_RESET = 24'd65536;

  typedef enum logic [2:0] {
    PH_LEAD    = 3'd0,
    PH_DIGITS  = 3'd1,
    PH_CRLF    = 3'd2,
    PH_DATA    = 3'd3,
    PH_TRAILER = 3'd4,
    PH_DONE    = 3'd5
  } chb_phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_OK   = 2'd1,
    KIND_ERR  = 2'd2
  } chb_kind_t;

  // Results caused by one input byte: an optional first beat (payload byte or
  // status) and an optional second beat (end-of-input status).
  typedef struct packed {
    logic                    v0;
    chb_kind_t               kind0;
    logic [7:0]              data0;
    logic [LEN_OUT_BITS-1:0] len0;
    logic                    v1;
    chb_kind_t               kind1;
    logic [LEN_OUT_BITS-1:0] len1;
  } chb_rec_t;

  typedef struct packed {
    logic     push;
    chb_rec_t rec;
  } chb_qwr_t;

  typedef struct packed {
    logic     valid;
    chb_rec_t rec;
  } chb_qrd_t;

endpackage

// ===== design/chb_front.sv =====
// Front end: accepts body bytes, runs the chunk parser, emits result records.
`include "assert_macros.svh"

module chb_front #(
  parameter int SIZE_BITS   = chb_pkg::SIZE_BITS_DEFAULT,
  parameter int LENGTH_BITS = chb_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,
  input  logic                         in_tlast,
  input  logic                         cfg_we,
  input  logic [chb_pkg::CFG_BITS-1:0] cfg_wdata,
  input  logic                         q_full,
  output chb_pkg::chb_qwr_t            qwr
);

  localparam int AW = SIZE_BITS + 1;
  localparam int CW = (AW > chb_pkg::CFG_BITS) ? AW : chb_pkg::CFG_BITS;
  localparam logic [AW-1:0] ACC_SAT = {1'b1, {SIZE_BITS{1'b0}}};
  localparam logic [1:0] TRAIL_SKIP = 2'd2;
  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;

  // {valid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) r = {1'b1, 4'(b - 8'h30)};
    else if (b inside {[8'h61:8'h66]}) r = {1'b1, 4'(b - 8'h57)};
    else if (b inside {[8'h41:8'h46]}) r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

  chb_pkg::chb_phase_t        ph_r, ph_m, ph_nxt;
  logic [AW-1:0]              acc_r, acc_m, acc_nxt, acc_dig;
  logic                       neg_r, neg_m, neg_nxt;
  logic                       dig_r, dig_m, dig_nxt;
  logic                       cr_r, cr_m, cr_nxt;
  logic [AW-1:0]              rem_r, rem_m, rem_nxt;
  logic [1:0]                 trl_r, trl_m, trl_nxt;
  logic [LENGTH_BITS-1:0]     cnt_r, cnt_m, cnt_nxt;
  logic [chb_pkg::CFG_BITS-1:0] max_r;

  logic [4:0]        hx;
  logic              is_blank, acc_over, in_acc;
  logic              e0_v, e1_v;
  chb_pkg::chb_kind_t e0_kind, e1_kind;
  logic [7:0]        e0_data;

  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;
  assign hx        = hex_decode(in_tdata);
  assign is_blank  = (in_tdata == CHAR_SP) || (in_tdata == CHAR_TAB);
  assign acc_over  = CW'(acc_r) > CW'(max_r);
  // acc*16 + digit, pinned at 2^SIZE_BITS once it would reach it
  assign acc_dig   = (acc_r[SIZE_BITS:SIZE_BITS-4] != '0) ? ACC_SAT :
                     {1'b0, acc_r[SIZE_BITS-5:0], hx[3:0]};

  always_comb begin : next_state
    ph_m = ph_r; acc_m = acc_r; neg_m = neg_r; dig_m = dig_r;
    cr_m = cr_r; rem_m = rem_r; trl_m = trl_r; cnt_m = cnt_r;
    e0_v = 1'b0; e0_kind = chb_pkg::KIND_BYTE; e0_data = 8'd0;
    case (ph_r)
      chb_pkg::PH_LEAD, chb_pkg::PH_DIGITS: begin
        if (hx[4]) begin
          acc_m = acc_dig;
          dig_m = 1'b1;
          ph_m  = chb_pkg::PH_DIGITS;
        end else if (ph_r == chb_pkg::PH_LEAD && is_blank) begin
          ph_m = chb_pkg::PH_LEAD;
        end else if (ph_r == chb_pkg::PH_LEAD && in_tdata == CHAR_MINUS) begin
          neg_m = 1'b1;
          ph_m  = chb_pkg::PH_DIGITS;
        end else if (!dig_r || acc_r == '0) begin
          e0_v    = 1'b1;
          e0_kind = chb_pkg::KIND_OK;
          ph_m    = chb_pkg::PH_DONE;
        end else if (neg_r || acc_over) begin
          e0_v    = 1'b1;
          e0_kind = chb_pkg::KIND_ERR;
          ph_m    = chb_pkg::PH_DONE;
        end else begin
          // size accepted; this byte already counts toward the CRLF hunt
          rem_m = acc_r;
          cr_m  = (in_tdata == CHAR_CR);
          ph_m  = chb_pkg::PH_CRLF;
        end
      end
      chb_pkg::PH_CRLF: begin
        if (in_tdata == CHAR_LF && cr_r) begin
          cr_m = 1'b0;
          ph_m = chb_pkg::PH_DATA;
        end else begin
          cr_m = (in_tdata == CHAR_CR);
        end
      end
      chb_pkg::PH_DATA: begin
        e0_v    = 1'b1;
        e0_data = in_tdata;
        if (cnt_r != '1) cnt_m = cnt_r + 1'b1;
        if (rem_r != '0) rem_m = rem_r - 1'b1;
        if (rem_m == '0) begin
          trl_m = TRAIL_SKIP;
          ph_m  = chb_pkg::PH_TRAILER;
        end
      end
      chb_pkg::PH_TRAILER: begin
        if (trl_r != 2'd0) trl_m = trl_r - 1'b1;
        if (trl_m == 2'd0) begin
          ph_m  = chb_pkg::PH_LEAD;
          acc_m = '0;
          neg_m = 1'b0;
          dig_m = 1'b0;
          cr_m  = 1'b0;
        end
      end
      default: begin
        ph_m = ph_r;
      end
    endcase

    if (in_tlast) begin
      ph_nxt = chb_pkg::PH_LEAD; acc_nxt = '0; neg_nxt = 1'b0; dig_nxt = 1'b0;
      cr_nxt = 1'b0; rem_nxt = '0; trl_nxt = 2'd0; cnt_nxt = '0;
    end else begin
      ph_nxt = ph_m; acc_nxt = acc_m; neg_nxt = neg_m; dig_nxt = dig_m;
      cr_nxt = cr_m; rem_nxt = rem_m; trl_nxt = trl_m; cnt_nxt = cnt_m;
    end
  end

  always_comb begin : outputs
    e1_v    = 1'b0;
    e1_kind = chb_pkg::KIND_ERR;
    if (in_tlast) begin
      case (ph_m)
        chb_pkg::PH_LEAD, chb_pkg::PH_DIGITS: begin
          e1_v    = 1'b1;
          e1_kind = (!dig_m || acc_m == '0) ? chb_pkg::KIND_OK : chb_pkg::KIND_ERR;
        end
        chb_pkg::PH_CRLF, chb_pkg::PH_DATA, chb_pkg::PH_TRAILER: begin
          e1_v = 1'b1;
        end
        default: begin
          e1_v = 1'b0;
        end
      endcase
    end
    qwr.push      = in_acc && (e0_v || e1_v);
    qwr.rec.v0    = e0_v;
    qwr.rec.kind0 = e0_kind;
    qwr.rec.data0 = e0_data;
    qwr.rec.len0  = chb_pkg::LEN_OUT_BITS'(cnt_r);
    qwr.rec.v1    = e1_v;
    qwr.rec.kind1 = e1_kind;
    qwr.rec.len1  = chb_pkg::LEN_OUT_BITS'(cnt_m);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= chb_pkg::PH_LEAD;
      acc_r <= '0;
      neg_r <= 1'b0;
      dig_r <= 1'b0;
      cr_r  <= 1'b0;
      rem_r <= '0;
      trl_r <= 2'd0;
      cnt_r <= '0;
      max_r <= chb_pkg::MAX_CHUNK_RESET;
    end else begin
      if (cfg_we) max_r <= cfg_wdata;
      if (in_acc) begin
        ph_r  <= ph_nxt;
        acc_r <= acc_nxt;
        neg_r <= neg_nxt;
        dig_r <= dig_nxt;
        cr_r  <= cr_nxt;
        rem_r <= rem_nxt;
        trl_r <= trl_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  `CHB_ASSERT(a_last_clears, clk, rst_n,
              (in_acc && in_tlast) |=> (ph_r == chb_pkg::PH_LEAD && cnt_r == '0),
              "message state not cleared after end of input")

endmodule

// ===== design/chb_fifo.sv =====
// Short record queue between parser front end and output back end.
`include "assert_macros.svh"

module chb_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  chb_pkg::chb_qwr_t qwr,
  output logic              q_full,
  input  logic              pop,
  output chb_pkg::chb_qrd_t qrd
);

  localparam int DEPTH = chb_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  chb_pkg::chb_rec_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign q_full    = (cnt_r == CW'(DEPTH));
  assign qrd.valid = (cnt_r != '0);
  assign qrd.rec   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (qwr.push) mem_r[wr_ptr_r] <= qwr.rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (qwr.push)
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (qwr.push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !qwr.push) cnt_r <= cnt_r - 1'b1;
    end
  end

  `CHB_NEVER(a_push_full, clk, rst_n, qwr.push && q_full, "push into full queue")
  `CHB_NEVER(a_pop_empty, clk, rst_n, pop && !qrd.valid, "pop from empty queue")

endmodule

// ===== design/chb_back.sv =====
// Back end: expands queued records into output beats through a holding register.
`include "assert_macros.svh"

module chb_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  chb_pkg::chb_qrd_t                qrd,
  output logic                             pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_data,
  output logic [chb_pkg::LEN_OUT_BITS-1:0] out_len,
  output chb_pkg::chb_kind_t               out_kind
);

  logic out_valid_r, half_r, load_ok;
  chb_pkg::chb_kind_t hold_kind_r, kind_r;
  logic [chb_pkg::LEN_OUT_BITS-1:0] hold_len_r, len_r;
  logic [7:0] data_r;

  assign load_ok    = !out_valid_r || out_tready;
  assign pop        = load_ok && !half_r && qrd.valid;
  assign out_tvalid = out_valid_r;
  assign out_data   = data_r;
  assign out_len    = len_r;
  assign out_kind   = kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      half_r      <= 1'b0;
    end else if (load_ok) begin
      if (half_r) begin
        out_valid_r <= 1'b1;
        half_r      <= 1'b0;
      end else begin
        out_valid_r <= qrd.valid;
        half_r      <= qrd.valid && qrd.rec.v0 && qrd.rec.v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      if (half_r) begin
        kind_r <= hold_kind_r;
        data_r <= 8'd0;
        len_r  <= hold_len_r;
      end else if (qrd.rec.v0) begin
        kind_r      <= qrd.rec.kind0;
        data_r      <= qrd.rec.data0;
        len_r       <= qrd.rec.len0;
        hold_kind_r <= qrd.rec.kind1;
        hold_len_r  <= qrd.rec.len1;
      end else begin
        kind_r <= qrd.rec.kind1;
        data_r <= 8'd0;
        len_r  <= qrd.rec.len1;
      end
    end
  end

  `CHB_ASSERT(a_dual_split, clk, rst_n,
              (pop && qrd.rec.v0 && qrd.rec.v1) |=> (half_r && out_valid_r),
              "two-beat record not split")

endmodule

// ===== design/http_chunked_body_decoder.sv =====
// A result beat passes from the parser through the record queue into the output register.
// Throughput: one body byte per cycle while the record queue is not full.
// A data byte that also ends the input yields two beats in one record.
// A 4-record queue between parser and output register absorbs output stalls.
// Reset (rst_n low, synchronous): parser back to start of a size line, counts
// zero, queue empty, max_chunk_size = 65536; no clearing pass.
module http_chunked_body_decoder #(
  parameter int SIZE_BITS   = chb_pkg::SIZE_BITS_DEFAULT,
  parameter int LENGTH_BITS = chb_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  // input beats: one raw body byte each
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_input
  // result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] payload_byte, [31:8] total_length
  output logic [1:0]  out_tuser,  // [1:0] kind: 0 byte, 1 done ok, 2 error
  // max_chunk_size register
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata
);

  chb_pkg::chb_qwr_t qwr;
  chb_pkg::chb_qrd_t qrd;
  logic              q_full, pop;
  logic [7:0]        out_data;
  logic [chb_pkg::LEN_OUT_BITS-1:0] out_len;
  chb_pkg::chb_kind_t out_kind;

  // Front: size-line parsing, CRLF hunt, data pass, trailer skip, status.
  chb_front #(
    .SIZE_BITS   (SIZE_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .qwr       (qwr)
  );

  // Records carry zero, one or two beats; empty records are never queued.
  chb_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .qwr    (qwr),
    .q_full (q_full),
    .pop    (pop),
    .qrd    (qrd)
  );

  // Back: output register, takes the next beat while the current one is taken.
  chb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qrd        (qrd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (out_data),
    .out_len    (out_len),
    .out_kind   (out_kind)
  );

  assign out_tdata = {out_len, out_data};
  assign out_tuser = out_kind;

endmodule

// ===== verif/http_chunked_body_decoder_tb.sv =====
// Self-checking testbench for the HTTP chunked body decoder: directed and random bodies.
`timescale 1ns / 1ps

module http_chunked_body_decoder_tb;

  localparam logic [7:0]  CR       = 8'h0D;
  localparam logic [7:0]  LF       = 8'h0A;
  localparam logic [7:0]  TAB      = 8'h09;
  localparam logic [24:0] SIZE_SAT = 25'h1000000;  // size accumulator ceiling
  localparam int          REPORT_LIMIT = 10;
  localparam int          PHASE_BEATS  = 125;      // least body bytes per random phase

  // one result beat as seen on out_*
  typedef struct packed {
    chb_pkg::chb_kind_t kind;
    logic [7:0]         data;
    logic [23:0]        len;
  } body_beat_t;

  // Tracks the decoder state byte by byte and keeps the beats still owed.
  class chunk_scoreboard;
    logic [23:0]         max_chunk;
    chb_pkg::chb_phase_t phase;
    logic [24:0]         size_acc;
    bit                  neg;
    bit                  seen_digit;
    bit                  prev_cr;
    logic [23:0]         remaining;
    logic [1:0]          skip_left;
    logic [23:0]         emitted;
    body_beat_t          pending[$];
    int                  mismatches;

    function new();
      max_chunk  = chb_pkg::MAX_CHUNK_RESET;
      mismatches = 0;
      clear_message();
    endfunction

    function void clear_message();
      phase      = chb_pkg::PH_LEAD;
      size_acc   = '0;
      neg        = 0;
      seen_digit = 0;
      prev_cr    = 0;
      remaining  = '0;
      skip_left  = '0;
      emitted    = '0;
    endfunction

    function void owe(chb_pkg::chb_kind_t kind, logic [7:0] data);
      body_beat_t b;
      b.kind = kind;
      b.data = data;
      b.len  = emitted;
      pending.push_back(b);
    endfunction

    function void crlf_step(logic [7:0] b);
      if (b == LF && prev_cr) begin
        prev_cr = 0;
        phase   = chb_pkg::PH_DATA;
      end else begin
        prev_cr = (b == CR);
      end
    endfunction

    // Accepted body byte: advance the parser and queue what it should produce.
    function void note_byte(logic [7:0] b, logic last);
      int          digit;
      logic [28:0] grown;
      digit = -1;
      if (b >= "0" && b <= "9") digit = b - "0";
      else if (b >= "a" && b <= "f") digit = b - "a" + 10;
      else if (b >= "A" && b <= "F") digit = b - "A" + 10;

      case (phase)
        chb_pkg::PH_LEAD, chb_pkg::PH_DIGITS: begin
          if (digit >= 0) begin
            grown = {size_acc, 4'h0} + digit[3:0];
            size_acc = (size_acc >= SIZE_SAT || grown >= SIZE_SAT) ? SIZE_SAT
                                                                   : grown[24:0];
            seen_digit = 1;
            phase = chb_pkg::PH_DIGITS;
          end else if (phase == chb_pkg::PH_LEAD && (b == " " || b == TAB)) begin
            // leading blank, nothing to do
          end else if (phase == chb_pkg::PH_LEAD && b == "-") begin
            neg   = 1;
            phase = chb_pkg::PH_DIGITS;
          end else if (!seen_digit || size_acc == 0) begin
            owe(chb_pkg::KIND_OK, 8'h00);
            phase = chb_pkg::PH_DONE;
          end else if (neg || size_acc > {1'b0, max_chunk}) begin
            owe(chb_pkg::KIND_ERR, 8'h00);
            phase = chb_pkg::PH_DONE;
          end else begin
            // terminating byte already counts toward the CR LF hunt
            remaining = size_acc[23:0];
            prev_cr   = 0;
            phase     = chb_pkg::PH_CRLF;
            crlf_step(b);
          end
        end
        chb_pkg::PH_CRLF: crlf_step(b);
        chb_pkg::PH_DATA: begin
          owe(chb_pkg::KIND_BYTE, b);
          if (emitted != 24'hFFFFFF) emitted++;
          if (remaining > 0) remaining--;
          if (remaining == 0) begin
            skip_left = 2;
            phase     = chb_pkg::PH_TRAILER;
          end
        end
        chb_pkg::PH_TRAILER: begin
          if (skip_left > 0) skip_left--;
          if (skip_left == 0) begin
            phase      = chb_pkg::PH_LEAD;
            size_acc   = '0;
            neg        = 0;
            seen_digit = 0;
            prev_cr    = 0;
          end
        end
        default: ;
      endcase

      if (last) begin
        if (phase == chb_pkg::PH_LEAD || phase == chb_pkg::PH_DIGITS) begin
          if (!seen_digit || size_acc == 0) owe(chb_pkg::KIND_OK, 8'h00);
          else owe(chb_pkg::KIND_ERR, 8'h00);
        end else if (phase == chb_pkg::PH_CRLF || phase == chb_pkg::PH_DATA ||
                     phase == chb_pkg::PH_TRAILER) begin
          owe(chb_pkg::KIND_ERR, 8'h00);
        end
        clear_message();
      end
    endfunction

    function void check_beat(chb_pkg::chb_kind_t kind, logic [7:0] data, logic [23:0] len);
      body_beat_t got;
      body_beat_t want;
      got.kind = kind;
      got.data = data;
      got.len  = len;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected beat kind=%0d byte=%02h len=%0d",
                   $time, got.kind, got.data, got.len);
      end else begin
        want = pending.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: exp kind=%0d byte=%02h len=%0d got kind=%0d byte=%02h len=%0d",
                     $time, want.kind, want.data, want.len, got.kind, got.data, got.len);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tlast = 1'b0;    // end_of_input
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [7:0] payload_byte, [31:8] total_length
  logic [1:0]  out_tuser;          // [1:0] kind
  logic        cfg_we = 1'b0;
  logic [23:0] cfg_wdata = 24'h0;

  chunk_scoreboard sb = new();

  int          in_idle_pct = 9;    // sender gap odds per beat, in percent
  int          out_idle_pct = 87;  // receiver stall odds per cycle, in percent
  int          phase_beats;
  logic [7:0]  body_q[$];

  http_chunked_body_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver backpressure: a fresh coin toss every cycle.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Result monitor. Values read right at the edge are the pre-edge ones,
  // so this sees exactly what the DUT sees for the handshake.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_beat(chb_pkg::chb_kind_t'(out_tuser), out_tdata[7:0], out_tdata[31:8]);
  end

  // Hard stop in case the DUT hangs.
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  // One beat on the input side, with random gaps ahead of it.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(b, last);
    phase_beats++;
  endtask

  // Whole body from body_q; the final byte carries the end mark.
  task automatic send_body();
    for (int i = 0; i < body_q.size(); i++)
      send_byte(body_q[i], i == body_q.size() - 1);
  endtask

  // Drain, let the pipeline settle, then load a new limit.
  task automatic set_max_chunk(input logic [23:0] v);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.max_chunk = v;
  endtask

  // Mostly well-formed chunked bodies with random content; some get broken.
  task automatic build_body();
    int          chunks;
    int          r;
    int          sz;
    int          n;
    logic [7:0]  hex_q[$];
    logic [3:0]  nib;
    body_q = {};
    chunks = $urandom_range(0, 3);
    for (int c = 0; c < chunks; c++) begin
      repeat ($urandom_range(0, 2)) body_q.push_back($urandom_range(1) ? " " : TAB);
      if ($urandom_range(99) < 6) body_q.push_back("-");
      if ($urandom_range(99) < 15) body_q.push_back("0");
      r = $urandom_range(99);
      hex_q = {};
      if (r < 90) begin
        sz = (r < 78) ? $urandom_range(1, 12) : $urandom_range(13, 40);
        n  = sz;
        do begin
          nib = n[3:0];
          hex_q.push_front(8'(nib < 10 ? "0" + nib
                              : ($urandom_range(1) ? "a" : "A") + nib - 10));
          n = n >> 4;
        end while (n != 0);
      end else begin
        // at least 2^24: the accumulator saturates and the size is rejected
        sz = 0;
        hex_q.push_back(8'("1" + $urandom_range(0, 8)));
        repeat ($urandom_range(6, 8)) hex_q.push_back($urandom_range(1) ? "F" : "c");
      end
      foreach (hex_q[i]) body_q.push_back(hex_q[i]);
      if ($urandom_range(99) < 20) begin
        body_q.push_back(";");
        repeat ($urandom_range(1, 3)) body_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end else if ($urandom_range(99) < 10) begin
        body_q.push_back(CR);   // stray CR before the real line end
      end
      body_q.push_back(CR);
      body_q.push_back(LF);
      repeat (sz) body_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(99) < 85) begin
        body_q.push_back(CR);
        body_q.push_back(LF);
      end else begin
        body_q.push_back(8'($urandom_range(0, 255)));
        body_q.push_back(8'($urandom_range(0, 255)));
      end
    end

    // closing part
    r = $urandom_range(99);
    if (r < 55) begin
      body_q.push_back("0");
      body_q.push_back(CR);
      body_q.push_back(LF);
      body_q.push_back(CR);
      body_q.push_back(LF);
    end else if (r < 70) begin
      body_q.push_back("0");
    end else if (r < 78) begin
      body_q.push_back("+");
    end else if (r < 88) begin
      // bytes after the status are ignored until the end mark
      body_q.push_back("0");
      body_q.push_back(CR);
      body_q.push_back(LF);
      repeat ($urandom_range(1, 6)) body_q.push_back(8'($urandom_range(0, 255)));
    end

    // damage
    r = $urandom_range(99);
    if (r < 8) begin
      body_q = {};
      repeat ($urandom_range(1, 12)) body_q.push_back(8'($urandom_range(0, 255)));
    end else if (r < 22 && body_q.size() > 1) begin
      n = $urandom_range(1, body_q.size() - 1);
      while (body_q.size() > n) void'(body_q.pop_back());
    end else if (r < 30 && body_q.size() > 0) begin
      body_q[$urandom_range(0, body_q.size() - 1)] = 8'($urandom_range(0, 255));
    end
    if (body_q.size() == 0) body_q.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin
    logic [23:0] limits[6];
    limits = '{24'd0, 24'hFFFFFF, 24'd8, 24'd30, 24'd0, 24'd16};
    limits[4] = 24'($urandom_range(1, 40));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed bodies at the reset limit.
    // blanks, extension, extreme data bytes, zero chunk ending on its digit
    body_q = {8'h20, TAB, "2", ";", "x", CR, LF, 8'h00, 8'hFF, CR, LF, "0"};
    send_body();
    // negative size, then ignored bytes up to the end mark
    body_q = {"-", "5", LF, 8'hA5};
    send_body();
    // plus sign is not a sign: empty size line means success
    body_q = {"+"};
    send_body();
    // end mark on a data byte: the byte, then an error
    body_q = {"1", CR, LF, "A"};
    send_body();
    // nonzero size cut off inside the size line
    body_q = {"a"};
    send_body();
    // end mark on the second trailer byte: success
    body_q = {"1", CR, LF, "Z", CR, LF};
    send_body();

    // Random phases, each under its own limit; the idle pattern changes every two phases.
    for (int p = 0; p < 6; p++) begin
      set_max_chunk(limits[p]);
      if (p < 2) begin
        in_idle_pct  = 9;
        out_idle_pct = 87;
      end else if (p < 4) begin
        in_idle_pct  = 87;
        out_idle_pct = 9;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      phase_beats = 0;
      while (phase_beats < PHASE_BEATS) begin
        build_body();
        send_body();
      end
    end

    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== http_chunked_body_decoder.f =====
+incdir+design
design/chb_pkg.sv
design/chb_front.sv
design/chb_fifo.sv
design/chb_back.sv
design/http_chunked_body_decoder.sv
verif/http_chunked_body_decoder_tb.sv
